// ===== rtl/per_row_top_k_heap_index_unit_macros.svh =====
// assertion macros for the per-row top-k heap index unit
// included by rtl files that carry concurrent assertions
`ifndef PER_ROW_TOP_K_HEAP_INDEX_UNIT_MACROS_SVH
`define PER_ROW_TOP_K_HEAP_INDEX_UNIT_MACROS_SVH

// same-cycle implication
`define PHKI_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHKI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/phki_pkg.sv =====
// shared types and codes of the per-row top-k heap index unit
// no dependencies
package phki_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_ROW    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        column;
    logic signed [31:0] value;
    logic [4:0]         fill;
    logic               kept;
    logic               last;
  } res_t;

endpackage

// ===== rtl/phki_intf.sv =====
// request and response channel interfaces of the heap index unit
// no dependencies
interface phki_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         table_sel;
  logic [15:0]        row_index;
  logic [31:0]        column_id;
  logic signed [31:0] cell_value;

  modport source (output valid, op, table_sel, row_index, column_id, cell_value,
                  input ready);
  modport sink (input valid, op, table_sel, row_index, column_id, cell_value,
                output ready);
endinterface

interface phki_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        out_column;
  logic signed [31:0] out_value;
  logic [4:0]         row_fill;
  logic               kept;
  logic               last;

  modport source (output valid, status, out_column, out_value, row_fill, kept, last,
                  input ready);
  modport sink (input valid, status, out_column, out_value, row_fill, kept, last,
                output ready);
endinterface

// ===== rtl/phki_sdp_ram.sv =====
// simple dual-port ram, one write and one registered read port
// no dependencies
module phki_sdp_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/per_row_top_k_heap_index_unit.sv =====
// top level of the per-row top-k heap index unit
// uses phki_pkg, phki_intf (req/rsp interfaces), phki_sdp_ram and the macros header
//
//  channel  | dir | transfer when        | payload
//  req_i    | in  | valid & ready        | op, table_sel, row_index, column_id, cell_value
//  rsp_o    | out | valid & ready        | status, out_column, out_value, row_fill, kept, last
//  cfg      | in  | cfg_we_i             | cfg_wdata_i -> table_present
//
// one request at a time; a replace sifts level by level, a lookup scans slots in order, a row read
//   fetches and emits one cell at a time, and the filling insert heapifies node by node from the
//   last inner node down to the root; all of these share the cell memory's single read port
// reset clears control only; memories are not swept at reset
// a table going present starts a clearing pass over the fill counts of its rows,
//   during which req_i.ready stays low
// the response register frees as the sink takes a transfer; a stalled sink holds the sequencer
`include "per_row_top_k_heap_index_unit_macros.svh"

module per_row_top_k_heap_index_unit
  import phki_pkg::*;
#(
  parameter int CELLS_PER_ROW = 8,
  parameter int ROWS          = 256,
  parameter int TABLES        = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  phki_req_if.sink   req_i,
  phki_rsp_if.source rsp_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  // derived sizes
  localparam int RowTotal  = TABLES * ROWS;
  localparam int CellTotal = RowTotal * CELLS_PER_ROW;
  localparam int Riw       = (RowTotal > 1) ? $clog2(RowTotal) : 1;
  localparam int Caw       = $clog2(CellTotal);
  localparam int Sw        = $clog2(CELLS_PER_ROW);
  localparam int Fw        = $clog2(CELLS_PER_ROW + 1);
  localparam int Rw        = (ROWS > 1) ? $clog2(ROWS) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FETCH   = 4'd1;
  localparam logic [3:0] S_ROOT    = 4'd2;
  localparam logic [3:0] S_HEAP_RD = 4'd3;
  localparam logic [3:0] S_HEAP_LD = 4'd4;
  localparam logic [3:0] S_SIFT_L  = 4'd5;
  localparam logic [3:0] S_SIFT_R  = 4'd6;
  localparam logic [3:0] S_SIFT_C  = 4'd7;
  localparam logic [3:0] S_SC_ISS  = 4'd8;
  localparam logic [3:0] S_SC_CHK  = 4'd9;
  localparam logic [3:0] S_RD_ISS  = 4'd10;
  localparam logic [3:0] S_RD_CHK  = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;

  logic [3:0] state_q, state_d;

  // request context
  logic [1:0]         op_q, op_d;
  logic [31:0]        col_q, col_d;
  logic signed [31:0] val_q, val_d;
  logic [Riw-1:0]     ri_q, ri_d;
  logic [Fw-1:0]      fill_q, fill_d;
  logic [Sw-1:0]      idx_q, idx_d;     // scan / read slot
  logic [Sw-1:0]      hs_q, hs_d;       // heapify start node
  logic               heap_q, heap_d;   // sift belongs to heapify
  logic [Sw-1:0]      pos_q, pos_d;     // sift position
  logic [63:0]        elem_q, elem_d;   // cell being sifted
  logic [63:0]        left_q, left_d;
  res_t               res_q, res_d;

  // table registry and fill-count clearing
  logic [3:0]     present_q;
  logic           clr_active_q;
  logic [3:0]     clr_mask_q;
  logic [1:0]     clr_tbl_q;
  logic [Rw-1:0]  clr_row_q;
  logic [3:0]     new_tables;

  // response register
  logic  out_valid_q;
  res_t  out_q;
  logic  out_free;

  // memory ports
  logic           cell_we;
  logic [5:0]     cell_wslot, cell_rslot;
  logic [63:0]    cell_wdata, cell_rdata;
  logic [Caw-1:0] cell_waddr, cell_raddr;

  logic           fill_we, fill_we_item;
  logic [Riw-1:0] fill_waddr, fill_raddr;
  logic [Fw-1:0]  fill_wdata, fill_wdata_item, fill_rdata;

  logic           req_acc;
  logic           req_bad;
  logic [Riw-1:0] ri_in;

  assign req_i.ready = (state_q == S_IDLE) && !clr_active_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign req_bad = (req_i.op != OP_INSERT && req_i.op != OP_LOOKUP && req_i.op != OP_ROW)
                || (32'(req_i.table_sel) >= TABLES) || !present_q[req_i.table_sel]
                || (32'(req_i.row_index) >= ROWS);
  assign ri_in = Riw'(32'(req_i.table_sel) * ROWS + 32'(req_i.row_index));

  // cell addresses: row base plus slot
  assign cell_waddr = Caw'(32'(ri_q) * CELLS_PER_ROW + 32'(cell_wslot));
  assign cell_raddr = Caw'(32'(ri_q) * CELLS_PER_ROW + 32'(cell_rslot));

  // fill memory: clearing pass owns the write port while active
  assign fill_raddr = ri_in;
  assign fill_we    = clr_active_q ? clr_mask_q[clr_tbl_q] : fill_we_item;
  assign fill_waddr = clr_active_q ? Riw'(32'(clr_tbl_q) * ROWS + 32'(clr_row_q)) : ri_q;
  assign fill_wdata = clr_active_q ? '0 : fill_wdata_item;

  phki_sdp_ram #(.Width(64), .Depth(CellTotal)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  phki_sdp_ram #(.Width(Fw), .Depth(RowTotal)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  // sequencer
  always_comb begin
    logic [Fw-1:0]      f;
    logic [5:0]         l, r;
    logic [5:0]         m;
    logic [63:0]        minc;
    logic               done;
    state_d  = state_q;
    op_d     = op_q;
    col_d    = col_q;
    val_d    = val_q;
    ri_d     = ri_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    hs_d     = hs_q;
    heap_d   = heap_q;
    pos_d    = pos_q;
    elem_d   = elem_q;
    left_d   = left_q;
    res_d    = res_q;
    cell_we  = 1'b0;
    cell_wslot = 6'(pos_q);
    cell_wdata = elem_q;
    cell_rslot = '0;
    fill_we_item    = 1'b0;
    fill_wdata_item = fill_q;
    done = 1'b0;
    l    = 6'((32'(pos_q) << 1) + 1);
    r    = l + 6'd1;
    m    = 6'(pos_q);
    minc = elem_q;
    f    = (32'(fill_rdata) > CELLS_PER_ROW) ? Fw'(CELLS_PER_ROW) : fill_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          op_d  = req_i.op;
          col_d = req_i.column_id;
          val_d = req_i.cell_value;
          ri_d  = ri_in;
          if (req_bad) begin
            res_d   = '{ST_BAD, 32'd0, 32'sd0, 5'd0, 1'b0, 1'b1};
            state_d = S_EMIT;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        fill_d = f;
        idx_d  = '0;
        unique case (op_q)
          OP_INSERT: begin
            if (32'(f) < CELLS_PER_ROW) begin
              // append in the next free slot
              cell_we    = 1'b1;
              cell_wslot = 6'(f);
              cell_wdata = {col_q, val_q};
              fill_we_item    = 1'b1;
              fill_wdata_item = f + Fw'(1);
              fill_d = f + Fw'(1);
              if (32'(f) + 1 == CELLS_PER_ROW) begin
                heap_d  = 1'b1;
                hs_d    = Sw'(CELLS_PER_ROW / 2 - 1);
                state_d = S_HEAP_RD;
              end else begin
                res_d   = '{ST_OK, 32'd0, 32'sd0, 5'(f + Fw'(1)), 1'b1, 1'b1};
                state_d = S_EMIT;
              end
            end else begin
              cell_rslot = '0;
              state_d    = S_ROOT;
            end
          end
          OP_LOOKUP: begin
            if (f == '0) begin
              res_d   = '{ST_MISS, 32'd0, 32'sd0, 5'd0, 1'b0, 1'b1};
              state_d = S_EMIT;
            end else begin
              state_d = S_SC_ISS;
            end
          end
          default: begin
            if (f == '0) begin
              res_d   = '{ST_OK, 32'd0, 32'sd0, 5'd0, 1'b0, 1'b1};
              state_d = S_EMIT;
            end else begin
              state_d = S_RD_ISS;
            end
          end
        endcase
      end
      S_ROOT: begin
        // full row: drop below the minimum, else replace root and sift
        if (val_q < $signed(cell_rdata[31:0])) begin
          res_d   = '{ST_OK, 32'd0, 32'sd0, 5'(fill_q), 1'b0, 1'b1};
          state_d = S_EMIT;
        end else begin
          elem_d  = {col_q, val_q};
          pos_d   = '0;
          heap_d  = 1'b0;
          state_d = S_SIFT_L;
        end
      end
      S_HEAP_RD: begin
        cell_rslot = 6'(hs_q);
        state_d    = S_HEAP_LD;
      end
      S_HEAP_LD: begin
        elem_d  = cell_rdata;
        pos_d   = hs_q;
        state_d = S_SIFT_L;
      end
      S_SIFT_L: begin
        if (32'(l) < CELLS_PER_ROW) begin
          cell_rslot = l;
          state_d    = S_SIFT_R;
        end else begin
          cell_we = 1'b1;
          done    = 1'b1;
        end
      end
      S_SIFT_R: begin
        left_d     = cell_rdata;
        cell_rslot = (32'(r) < CELLS_PER_ROW) ? r : l;
        state_d    = S_SIFT_C;
      end
      S_SIFT_C: begin
        // strictly smaller child only, left wins ties
        if ($signed(left_q[31:0]) < $signed(elem_q[31:0])) begin
          m    = l;
          minc = left_q;
        end
        if (32'(r) < CELLS_PER_ROW && $signed(cell_rdata[31:0]) < $signed(minc[31:0])) begin
          m    = r;
          minc = cell_rdata;
        end
        cell_we = 1'b1;
        if (m == 6'(pos_q)) begin
          done = 1'b1;
        end else begin
          cell_wdata = minc;
          pos_d      = Sw'(m);
          state_d    = S_SIFT_L;
        end
      end
      S_SC_ISS: begin
        cell_rslot = 6'(idx_q);
        state_d    = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (cell_rdata[63:32] == col_q) begin
          res_d   = '{ST_OK, col_q, $signed(cell_rdata[31:0]), 5'(fill_q), 1'b0, 1'b1};
          state_d = S_EMIT;
        end else if (Fw'(idx_q) + Fw'(1) == fill_q) begin
          res_d   = '{ST_MISS, 32'd0, 32'sd0, 5'(fill_q), 1'b0, 1'b1};
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + Sw'(1);
          state_d = S_SC_ISS;
        end
      end
      S_RD_ISS: begin
        cell_rslot = 6'(idx_q);
        state_d    = S_RD_CHK;
      end
      S_RD_CHK: begin
        res_d = '{ST_OK, cell_rdata[63:32], $signed(cell_rdata[31:0]), 5'(fill_q), 1'b0,
                  Fw'(idx_q) + Fw'(1) == fill_q};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (res_q.last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + Sw'(1);
            state_d = S_RD_ISS;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of one sift: next heapify node or report
    if (done) begin
      if (heap_q && hs_q != '0) begin
        hs_d    = hs_q - Sw'(1);
        state_d = S_HEAP_RD;
      end else begin
        res_d   = '{ST_OK, 32'd0, 32'sd0, 5'(fill_q), 1'b1, 1'b1};
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    col_q  <= col_d;
    val_q  <= val_d;
    ri_q   <= ri_d;
    fill_q <= fill_d;
    idx_q  <= idx_d;
    hs_q   <= hs_d;
    heap_q <= heap_d;
    pos_q  <= pos_d;
    elem_q <= elem_d;
    left_q <= left_d;
    res_q  <= res_d;
  end

  // table registry; a newly present table gets its fill counts swept to zero
  assign new_tables = cfg_wdata_i & ~present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      clr_active_q <= 1'b0;
      clr_mask_q   <= '0;
      clr_tbl_q    <= '0;
      clr_row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
      if (cfg_we_i && new_tables != '0) begin
        // restart the sweep so earlier pending tables are covered too
        clr_active_q <= 1'b1;
        clr_mask_q   <= (clr_active_q ? clr_mask_q : 4'd0) | new_tables;
        clr_tbl_q    <= '0;
        clr_row_q    <= '0;
      end else if (clr_active_q) begin
        if (32'(clr_row_q) == ROWS - 1) begin
          clr_row_q <= '0;
          if (32'(clr_tbl_q) == TABLES - 1) begin
            clr_active_q <= 1'b0;
          end else begin
            clr_tbl_q <= clr_tbl_q + 2'd1;
          end
        end else begin
          clr_row_q <= clr_row_q + Rw'(1);
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.out_column = out_q.column;
  assign rsp_o.out_value  = out_q.value;
  assign rsp_o.row_fill   = out_q.fill;
  assign rsp_o.kept       = out_q.kept;
  assign rsp_o.last       = out_q.last;

  `PHKI_ASSERT_IMPL(a_clear_only_idle, clk_i, rst_ni, clr_active_q, state_q == S_IDLE, "clear sweep overlaps a request")
  `PHKI_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, req_acc, state_q != S_IDLE, "accepted request not started")
  `PHKI_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, fill_we_item && !clr_active_q, 32'(fill_wdata_item) <= CELLS_PER_ROW, "fill count beyond row size")
  `PHKI_ASSERT_IMPL(a_rsp_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_EMIT, "response loaded outside emit")

endmodule

// ===== bench/phki_checker.sv =====
// scoreboard for the per-row top-k heap index unit: mirrors rows, heaps and the present mask
// depends on phki_pkg and the phki_req_if / phki_rsp_if interfaces
module phki_checker
  import phki_pkg::*;
#(
  parameter int CELLS_PER_ROW = 8,
  parameter int ROWS          = 256,
  parameter int TABLES        = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  phki_req_if        req,
  phki_rsp_if        rsp,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output int         pending_o,
  output int         errors_o,
  output int         checked_o
);

  logic [31:0]        col_mem [TABLES][ROWS][CELLS_PER_ROW];
  logic signed [31:0] val_mem [TABLES][ROWS][CELLS_PER_ROW];
  logic [4:0]         fill_mem [TABLES][ROWS];
  logic [3:0]         present;
  res_t               expected_q [$];
  int                 err_cnt = 0;
  int                 chk_cnt = 0;
  int                 pend_cnt = 0;

  assign pending_o = pend_cnt;
  assign errors_o  = err_cnt;
  assign checked_o = chk_cnt;

  function automatic void swap_slots(int t, int r, int a, int b);
    logic [31:0]        c;
    logic signed [31:0] v;
    c = col_mem[t][r][a];
    v = val_mem[t][r][a];
    col_mem[t][r][a] = col_mem[t][r][b];
    val_mem[t][r][a] = val_mem[t][r][b];
    col_mem[t][r][b] = c;
    val_mem[t][r][b] = v;
  endfunction

  // min-heap sift; only a strictly smaller child moves up, left wins ties
  function automatic void sift_down(int t, int r, int pos);
    int l;
    int m;
    forever begin
      l = 2 * pos + 1;
      m = pos;
      if (l < CELLS_PER_ROW && val_mem[t][r][l] < val_mem[t][r][m]) m = l;
      if (l + 1 < CELLS_PER_ROW && val_mem[t][r][l + 1] < val_mem[t][r][m]) m = l + 1;
      if (m == pos) return;
      swap_slots(t, r, pos, m);
      pos = m;
    end
  endfunction

  function automatic res_t make_res(logic [1:0] st, logic [31:0] c, logic signed [31:0] v,
                                    logic [4:0] f, logic k, logic l);
    res_t x;
    x.status = st;
    x.column = c;
    x.value  = v;
    x.fill   = f;
    x.kept   = k;
    x.last   = l;
    return x;
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [1:0] t, logic [15:0] row,
                                          logic [31:0] col, logic signed [31:0] val);
    int  f;
    int  r;
    bit  hit;
    if (op != OP_INSERT && op != OP_LOOKUP && op != OP_ROW || int'(t) >= TABLES ||
        !present[t] || int'(row) >= ROWS) begin
      expected_q.push_back(make_res(ST_BAD, '0, '0, '0, 1'b0, 1'b1));
      return;
    end
    r = int'(row);
    f = int'(fill_mem[t][r]);
    if (op == OP_INSERT) begin
      if (f < CELLS_PER_ROW) begin
        col_mem[t][r][f] = col;
        val_mem[t][r][f] = val;
        f++;
        fill_mem[t][r] = 5'(f);
        // row just filled: floyd heapify
        if (f == CELLS_PER_ROW)
          for (int s = CELLS_PER_ROW / 2 - 1; s >= 0; s--) sift_down(t, r, s);
        expected_q.push_back(make_res(ST_OK, '0, '0, 5'(f), 1'b1, 1'b1));
      end else if (val < val_mem[t][r][0]) begin
        expected_q.push_back(make_res(ST_OK, '0, '0, 5'(f), 1'b0, 1'b1));
      end else begin
        col_mem[t][r][0] = col;
        val_mem[t][r][0] = val;
        sift_down(t, r, 0);
        expected_q.push_back(make_res(ST_OK, '0, '0, 5'(f), 1'b1, 1'b1));
      end
    end else if (op == OP_LOOKUP) begin
      hit = 1'b0;
      for (int i = 0; i < f && !hit; i++)
        if (col_mem[t][r][i] == col) begin
          hit = 1'b1;
          expected_q.push_back(make_res(ST_OK, col, val_mem[t][r][i], 5'(f), 1'b0, 1'b1));
        end
      if (!hit) expected_q.push_back(make_res(ST_MISS, '0, '0, 5'(f), 1'b0, 1'b1));
    end else if (f == 0) begin
      expected_q.push_back(make_res(ST_OK, '0, '0, '0, 1'b0, 1'b1));
    end else begin
      for (int i = 0; i < f; i++)
        expected_q.push_back(make_res(ST_OK, col_mem[t][r][i], val_mem[t][r][i], 5'(f), 1'b0,
                                      i == f - 1));
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (!rst_ni) begin
      present = '0;
      foreach (fill_mem[t, r]) fill_mem[t][r] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        // a table going present empties all its rows
        for (int t = 0; t < TABLES; t++)
          if (cfg_wdata_i[t] && !present[t])
            for (int r = 0; r < ROWS; r++) fill_mem[t][r] = '0;
        present = cfg_wdata_i;
      end
      if (req.valid && req.ready)
        predict_request(req.op, req.table_sel, req.row_index, req.column_id, req.cell_value);
      if (rsp.valid && rsp.ready) begin
        chk_cnt++;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual status %h column %h",
                   $time, rsp.status, rsp.out_column);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", 32'(e.status), 32'(rsp.status));
          check_field("out_column", e.column, rsp.out_column);
          check_field("out_value", 32'(e.value), 32'(rsp.out_value));
          check_field("row_fill", 32'(e.fill), 32'(rsp.row_fill));
          check_field("kept", 32'(e.kept), 32'(rsp.kept));
          check_field("last", 32'(e.last), 32'(rsp.last));
        end
      end
    end
    pend_cnt = expected_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// top of the heap index unit bench: clock, reset, stimulus, config phases and verdict
// depends on phki_pkg, the channel interfaces, phki_checker and the unit itself
module testbench;
  import phki_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  int         pending;
  int         errors;
  int         checked;
  int         cycles = 0;
  int         sent = 0;
  bit         hold_rsp = 1'b0;
  bit         rsp_busy_mode = 1'b0;

  phki_req_if req ();
  phki_rsp_if rsp ();

  per_row_top_k_heap_index_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  phki_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req         (req),
    .rsp         (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors),
    .checked_o   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_rsp) begin
      rsp.ready <= 1'b0;
    end else if (rsp_busy_mode) begin
      rsp.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      rsp.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rsp_busy_mode <= !rsp_busy_mode;
  end

  // one request transfer, then an optional idle gap
  task automatic send_req(logic [1:0] op, logic [1:0] t, logic [15:0] row,
                          logic [31:0] col, logic [31:0] val, int gap);
    req.valid      <= 1'b1;
    req.op         <= op;
    req.table_sel  <= t;
    req.row_index  <= row;
    req.column_id  <= col;
    req.cell_value <= val;
    do @(posedge clk); while (!req.ready);
    sent++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write only once the unit has drained
  task automatic write_present(logic [3:0] mask);
    if (req.valid) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    wait (pending == 0);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_req(int gap);
    int          p;
    logic [1:0]  op;
    logic [15:0] row;
    logic [31:0] col;
    p = $urandom_range(0, 99);
    if (p < 50) op = OP_INSERT;
    else if (p < 72) op = OP_LOOKUP;
    else if (p < 95) op = OP_ROW;
    else op = 2'd3;
    // few rows so they fill and the heaps get exercised
    p = $urandom_range(0, 99);
    if (p < 80) row = 16'($urandom_range(0, 3));
    else if (p < 90) row = 16'd255;
    else row = 16'($urandom_range(0, 65535));
    col = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 15)) : $urandom;
    send_req(op, 2'($urandom_range(0, 3)), row, col, $urandom, gap);
  endtask

  initial begin
    req.valid      <= 1'b0;
    req.op         <= OP_INSERT;
    req.table_sel  <= '0;
    req.row_index  <= '0;
    req.column_id  <= '0;
    req.cell_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_present(4'hF);
    // directed: fill one row with extremes and ties, then probe it
    send_req(OP_ROW, 2'd0, 16'd0, 32'd0, 32'd0, 0);             // empty row read
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd1, 32'h8000_0000, 0);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd2, 32'h7FFF_FFFF, 0);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd3, 32'h0001_0000, 1);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd4, 32'h0001_0000, 0);  // equal children
    send_req(OP_INSERT, 2'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_0000, 0);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd6, 32'h0000_0000, 0);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd7, 32'h8000_0000, 2);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd8, 32'h0000_8000, 0);  // fills, heapify
    send_req(OP_ROW, 2'd0, 16'd0, 32'd0, 32'd0, 0);
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd9, 32'h8000_0000, 0);  // equal to root, kept
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd10, 32'hFFFF_FFFF, 0); // larger than root
    send_req(OP_INSERT, 2'd0, 16'd0, 32'd11, 32'h8000_0001, 0); // above root, kept
    send_req(OP_LOOKUP, 2'd0, 16'd0, 32'd2, 32'd0, 0);          // hit
    send_req(OP_LOOKUP, 2'd0, 16'd0, 32'd99, 32'd0, 0);         // miss
    send_req(OP_LOOKUP, 2'd1, 16'd5, 32'd0, 32'd0, 0);          // miss on empty row
    send_req(OP_ROW, 2'd0, 16'd0, 32'd0, 32'd0, 0);
    send_req(OP_INSERT, 2'd3, 16'd255, 32'd1, 32'h7FFF_FFFF, 0);
    send_req(OP_INSERT, 2'd1, 16'd256, 32'd1, 32'd1, 0);        // row out of range
    send_req(OP_LOOKUP, 2'd2, 16'hFFFF, 32'd1, 32'd1, 0);
    send_req(2'd3, 2'd0, 16'd0, 32'd0, 32'd0, 0);               // undefined op

    // missing tables, including lookups into them
    write_present(4'h5);
    send_req(OP_LOOKUP, 2'd1, 16'd0, 32'd1, 32'd0, 0);
    send_req(OP_INSERT, 2'd3, 16'd255, 32'd1, 32'd0, 0);
    send_req(OP_ROW, 2'd0, 16'd0, 32'd0, 32'd0, 0);

    // random phases across several masks; table re-creation empties its rows
    for (int i = 0; i < 110; i++) random_req(pick_gap());
    write_present(4'hA);
    for (int i = 0; i < 90; i++) random_req(pick_gap());
    // sink holds off long while requests keep coming
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 30; i++) random_req(0);
    join
    write_present(4'hF);
    for (int i = 0; i < 120; i++) random_req(($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    write_present(4'h0);
    for (int i = 0; i < 10; i++) random_req(pick_gap());
    write_present(4'hF);
    for (int i = 0; i < 70; i++) random_req(pick_gap());

    req.valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);

    $display("sent %0d requests over six table masks, checked %0d response transfers",
             sent, checked);
    $display("covered fill, heapify, root replace and drop, lookups, row reads, errors");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
